// ===== rtl/mi_pkg.sv =====
// Shared package of the modular inverse block.
// Holds the controller state type, the command and status structs and defaults.
// Depends on nothing.
package mi_pkg;

    localparam int WIDTH_DEFAULT = 31;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RALIGN,
        ST_RSUB,
        ST_RTEST,
        ST_EINIT,
        ST_ALIGN,
        ST_SUB,
        ST_STEP,
        ST_TEST,
        ST_FIX,
        ST_EMIT_OK,
        ST_EMIT_NONE
    } state_t;

    typedef struct packed {
        logic load;
        logic align;
        logic sub;
        logic einit;
        logic step;
        logic fix;
        logic emit_ok;
        logic emit_none;
    } cmd_t;

    typedef struct packed {
        logic m_small;
        logic rem_zero;
        logic can_align;
        logic cnt_zero;
        logic r1_zero;
        logic r0_one;
    } status_t;

endpackage

// ===== rtl/mi_ctrl.sv =====
// Controller of the modular inverse block: sequences reduction, division
// steps, Euclid updates and the final sign fix.
// Depends on mi_pkg.
module mi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  mi_pkg::status_t  status,
    output mi_pkg::cmd_t     cmd,
    output logic             busy
);
    import mi_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = status.m_small ? ST_EMIT_NONE : ST_RALIGN;
            end
            ST_RALIGN:
            begin
                if (!status.can_align)
                begin
                    state_next = ST_RSUB;
                end
            end
            ST_RSUB:
            begin
                if (status.cnt_zero)
                begin
                    state_next = ST_RTEST;
                end
            end
            ST_RTEST:
            begin
                state_next = status.rem_zero ? ST_EMIT_NONE : ST_EINIT;
            end
            ST_EINIT:
            begin
                state_next = ST_ALIGN;
            end
            ST_ALIGN:
            begin
                if (!status.can_align)
                begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB:
            begin
                if (status.cnt_zero)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                if (status.r1_zero)
                begin
                    state_next = status.r0_one ? ST_FIX : ST_EMIT_NONE;
                end
                else
                begin
                    state_next = ST_ALIGN;
                end
            end
            ST_FIX:
            begin
                state_next = ST_EMIT_OK;
            end
            ST_EMIT_OK:
            begin
                state_next = ST_IDLE;
            end
            ST_EMIT_NONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_RALIGN, ST_ALIGN:
            begin
                cmd.align = status.can_align;
            end
            ST_RSUB, ST_SUB:
            begin
                cmd.sub = 1'b1;
            end
            ST_EINIT:
            begin
                cmd.einit = 1'b1;
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
            end
            ST_FIX:
            begin
                cmd.fix = 1'b1;
            end
            ST_EMIT_OK:
            begin
                cmd.emit_ok = 1'b1;
            end
            ST_EMIT_NONE:
            begin
                cmd.emit_none = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/mi_datapath.sv =====
// Datapath of the modular inverse block: shift-subtract divider with
// shift-add quotient product, Euclid registers and result registers.
// Depends on mi_pkg.
module mi_datapath #(
    parameter int WIDTH = mi_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mi_pkg::cmd_t     cmd,
    input  logic [WIDTH-1:0] modulus,
    input  logic [WIDTH-1:0] operand,
    output mi_pkg::status_t  status,
    output logic [WIDTH-1:0] inverse_value,
    output logic             has_inverse,
    output logic             done
);
    import mi_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] m_reg,   m_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] d_reg,   d_next;
    logic [WIDTH-1:0] p_reg,   p_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [WIDTH-1:0] r0_reg,  r0_next;
    logic [WIDTH-1:0] r1_reg,  r1_next;
    logic [WIDTH-1:0] u0_reg,  u0_next;
    logic [WIDTH-1:0] u1_reg,  u1_next;
    logic             odd_reg, odd_next;
    logic [WIDTH-1:0] inv_reg, inv_next;
    logic             has_reg, has_next;
    logic             done_reg, done_next;

    logic             sub_ge;
    logic [WIDTH-1:0] d_dbl;

    assign sub_ge = (rem_reg >= d_reg);
    assign d_dbl  = {d_reg[WIDTH-2:0], 1'b0};

    assign status.m_small   = (m_reg < WIDTH'(2));
    assign status.rem_zero  = (rem_reg == '0);
    assign status.can_align = !d_reg[WIDTH-1] && (d_dbl <= rem_reg);
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.r1_zero   = (r1_reg == '0);
    assign status.r0_one    = (r0_reg == WIDTH'(1));

    always_comb
    begin
        m_next    = m_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        p_next    = p_reg;
        cnt_next  = cnt_reg;
        r0_next   = r0_reg;
        r1_next   = r1_reg;
        u0_next   = u0_reg;
        u1_next   = u1_reg;
        odd_next  = odd_reg;
        inv_next  = inv_reg;
        has_next  = has_reg;
        done_next = 1'b0;

        if (cmd.load)
        begin
            m_next   = modulus;
            rem_next = operand;
            d_next   = modulus;
            p_next   = '0;
            cnt_next = '0;
        end
        if (cmd.align)
        begin
            d_next   = d_dbl;
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmd.sub)
        begin
            // quotient bits arrive MSB first; p accumulates q * u1
            if (sub_ge)
            begin
                rem_next = rem_reg - d_reg;
            end
            p_next   = {p_reg[WIDTH-2:0], 1'b0} + (sub_ge ? u1_reg : '0);
            d_next   = {1'b0, d_reg[WIDTH-1:1]};
            cnt_next = cnt_reg - CW'(1);
        end
        if (cmd.einit)
        begin
            r0_next  = m_reg;
            r1_next  = rem_reg;
            u0_next  = '0;
            u1_next  = WIDTH'(1);
            odd_next = 1'b0;
            rem_next = m_reg;
            d_next   = rem_reg;
            p_next   = '0;
            cnt_next = '0;
        end
        if (cmd.step)
        begin
            r0_next  = r1_reg;
            r1_next  = rem_reg;
            u0_next  = u1_reg;
            u1_next  = u0_reg + p_reg;
            odd_next = !odd_reg;
            rem_next = r1_reg;
            d_next   = rem_reg;
            p_next   = '0;
            cnt_next = '0;
        end
        if (cmd.fix)
        begin
            if (u0_reg >= m_reg)
            begin
                u0_next = u0_reg - m_reg;
            end
        end
        if (cmd.emit_ok)
        begin
            inv_next  = (!odd_reg && (u0_reg != '0)) ? (m_reg - u0_reg) : u0_reg;
            has_next  = 1'b1;
            done_next = 1'b1;
        end
        if (cmd.emit_none)
        begin
            inv_next  = '0;
            has_next  = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_reg  <= 1'b0;
            done_reg <= 1'b0;
            inv_reg  <= '0;
        end
        else
        begin
            has_reg  <= has_next;
            done_reg <= done_next;
            inv_reg  <= inv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg   <= m_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        p_reg   <= p_next;
        cnt_reg <= cnt_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        u0_reg  <= u0_next;
        u1_reg  <= u1_next;
        odd_reg <= odd_next;
    end

    assign inverse_value = inv_reg;
    assign has_inverse   = has_reg;
    assign done          = done_reg;

    a_inv_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && has_reg |-> (inv_reg != '0) && (inv_reg < m_reg))
        else $error("inverse out of range");

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !has_reg |-> (inv_reg == '0))
        else $error("nonzero value without inverse");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("done held longer than one cycle");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.align, cmd.sub, cmd.einit, cmd.step, cmd.fix,
                  cmd.emit_ok, cmd.emit_none}))
        else $error("conflicting datapath commands");

endmodule

// ===== rtl/modular_inverse.sv =====
// Top level of the modular inverse block (extended Euclid, continuant form).
// Depends on mi_pkg, mi_ctrl and mi_datapath.
//
//  channel  | handshake            | fields
//  ---------+----------------------+------------------------------
//  input    | start & !busy        | modulus, operand
//  result   | done (one cycle)     | inverse_value, has_inverse
//
// One item at a time; busy is high from the transfer until the result cycle.
// The operand is first reduced modulo the modulus. Each division aligns the divisor
// by doubling it while it fits, then subtracts and halves it, giving quotient bits
// MSB first; each Euclid step adds a step and a test state. A modulus below two
// goes straight from the check to the no-inverse result.
// Reset is asynchronous and clears the controller and the result strobe.
// The receiver cannot stall: done marks the result for exactly one cycle.
module modular_inverse #(
    parameter int WIDTH = mi_pkg::WIDTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] modulus,
    input  logic [WIDTH-1:0] operand,
    output logic [WIDTH-1:0] inverse_value,
    output logic             has_inverse,
    output logic             done
);
    import mi_pkg::*;

    cmd_t    cmd;
    status_t status;

    mi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    mi_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .modulus       (modulus),
        .operand       (operand),
        .status        (status),
        .inverse_value (inverse_value),
        .has_inverse   (has_inverse),
        .done          (done)
    );

endmodule
